/* rtl/sample_set_statistics_assert.svh */
`ifndef SAMPLE_SET_STATISTICS_ASSERT_SVH
`define SAMPLE_SET_STATISTICS_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define SSST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sample_set_statistics check failed");

// next-cycle implication on clk_i, off during reset
`define SSST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sample_set_statistics check failed");

`endif

/* rtl/ssst_pkg.sv */
package ssst_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int DATA_W      = 32;
  localparam int VCNT_W      = 9;
  localparam int CNT_W       = ($clog2(MAX_SAMPLES + 1) > VCNT_W) ?
                               $clog2(MAX_SAMPLES + 1) : VCNT_W;
  localparam int SUM_W       = DATA_W + $clog2(MAX_SAMPLES) + 1;
  localparam int STEP_W      = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NONE  = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  // chain control: sorted insert of the request sample, or shift toward the head
  typedef struct packed {
    logic ins;
    logic shl;
  } ctl_t;

endpackage

/* rtl/ssst_cell.sv */
module ssst_cell (
  input  logic                                 clk_i,
  input  ssst_pkg::ctl_t                       ctl_i,
  input  logic signed [ssst_pkg::DATA_W-1:0]   sample_i,
  input  logic signed [ssst_pkg::DATA_W-1:0]   left_val_i,
  input  logic signed [ssst_pkg::DATA_W-1:0]   right_val_i,
  input  logic                                 left_gt_i,
  input  logic                                 used_i,
  input  logic                                 at_end_i,
  output logic                                 gt_o,
  output logic signed [ssst_pkg::DATA_W-1:0]   val_o
);
  import ssst_pkg::*;

  logic signed [DATA_W-1:0] val_q, val_d;

  assign gt_o  = used_i && (val_q > sample_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shl) begin
      val_d = right_val_i;
    end else if (ctl_i.ins) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || at_end_i) begin
        val_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

/* rtl/ssst_chain.sv */
module ssst_chain (
  input  logic                                 clk_i,
  input  ssst_pkg::ctl_t                       ctl_i,
  input  logic signed [ssst_pkg::DATA_W-1:0]   sample_i,
  input  logic        [ssst_pkg::CNT_W-1:0]    cnt_i,
  output logic signed [ssst_pkg::DATA_W-1:0]   head_o
);
  import ssst_pkg::*;

  logic signed [DATA_W-1:0] vals [MAX_SAMPLES];
  logic                     gts  [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val, right_val;
    logic                     left_gt;

    if (i == 0) begin : g_first
      assign left_val = sample_i;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = vals[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    ssst_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .sample_i   (sample_i),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .left_gt_i  (left_gt),
      .used_i     (cnt_i > CNT_W'(i)),
      .at_end_i   (cnt_i == CNT_W'(i)),
      .gt_o       (gts[i]),
      .val_o      (vals[i])
    );
  end

  assign head_o = vals[0];

endmodule

/* rtl/ssst_div.sv */
module ssst_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ssst_pkg::SUM_W-1:0]    dividend_i,
  input  logic [ssst_pkg::CNT_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [ssst_pkg::SUM_W-1:0]    quo_o
);
  import ssst_pkg::*;

  logic              run_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, div_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      step_q <= STEP_W'(SUM_W);
    end else if (run_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign busy_o = run_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/sample_set_statistics.sv */
// Gathers one list of signed Q23.8 samples, one request per cycle while busy is
// low, keeping valid ones sorted in a row of cells with running sum, minimum
// and maximum. A request that carries no sample and does not close the list
// gives no result. An empty-list request gives its result on valid_o in the
// next cycle and busy stays low. A closing request raises busy until its
// result is formed; when no sample is kept it skips the divider. Else the
// 41-step serial divider forms the mean while the cell row shifts toward
// its head to reach the middle elements. The result is on the
// outputs for exactly one cycle, with valid_o high, in the first cycle that
// busy is low again, and must be taken then; a new request may start in that
// same cycle.
`include "sample_set_statistics_assert.svh"

module sample_set_statistics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ssst_pkg::DATA_W-1:0]    sample_value_i,
  input  logic                                  sample_present_i,
  input  logic                                  list_end_i,
  input  logic                                  empty_list_i,
  output logic                                  valid_o,
  output logic        [1:0]                     status_o,
  output logic        [ssst_pkg::VCNT_W-1:0]    valid_count_o,
  output logic signed [ssst_pkg::DATA_W-1:0]    mean_value_o,
  output logic signed [ssst_pkg::DATA_W-1:0]    median_value_o,
  output logic signed [ssst_pkg::DATA_W-1:0]    min_value_o,
  output logic signed [ssst_pkg::DATA_W-1:0]    max_value_o
);
  import ssst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN} state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         cnt_q, med_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W-1:0] min_q, max_q, prev_q;
  logic                     ovf_q, neg_q;

  logic                     acc, full, ins, drop;
  ctl_t                     ctl;
  logic signed [DATA_W-1:0] head;
  logic                     div_start, div_busy;
  logic [SUM_W-1:0]         sum_mag, quo, mean_full;
  logic signed [DATA_W:0]   mid_sum;
  logic signed [DATA_W-1:0] median;
  logic                     stats_ordered;

  assign busy = (state_q != S_IDLE);
  assign acc  = start && !busy;
  assign full = (cnt_q == CNT_W'(MAX_SAMPLES));
  assign ins  = acc && !empty_list_i && sample_present_i && !full;
  assign drop = acc && !empty_list_i && sample_present_i && full;

  assign ctl.ins = ins;
  assign ctl.shl = (state_q == S_RUN) && (med_q != '0);

  ssst_chain u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .sample_i(sample_value_i),
    .cnt_i   (cnt_q),
    .head_o  (head)
  );

  assign div_start = (state_q == S_LOAD) && (cnt_q != '0);
  assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  ssst_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_mag),
    .divisor_i (cnt_q),
    .busy_o    (div_busy),
    .quo_o     (quo)
  );

  assign mean_full = neg_q ? SUM_W'(-quo) : quo;
  assign mid_sum   = {head[DATA_W-1], head} + {prev_q[DATA_W-1], prev_q};
  assign median    = cnt_q[0] ? head : mid_sum[DATA_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cnt_q          <= '0;
      med_q          <= '0;
      sum_q          <= '0;
      min_q          <= {1'b0, {(DATA_W-1){1'b1}}};
      max_q          <= {1'b1, {(DATA_W-1){1'b0}}};
      prev_q         <= '0;
      ovf_q          <= 1'b0;
      neg_q          <= 1'b0;
      valid_o        <= 1'b0;
      status_o       <= ST_OK;
      valid_count_o  <= '0;
      mean_value_o   <= '0;
      median_value_o <= '0;
      min_value_o    <= '0;
      max_value_o    <= '0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc && empty_list_i) begin
            valid_o        <= 1'b1;
            status_o       <= ST_EMPTY;
            valid_count_o  <= '0;
            mean_value_o   <= '0;
            median_value_o <= '0;
            min_value_o    <= '0;
            max_value_o    <= '0;
            cnt_q          <= '0;
            sum_q          <= '0;
            min_q          <= {1'b0, {(DATA_W-1){1'b1}}};
            max_q          <= {1'b1, {(DATA_W-1){1'b0}}};
            ovf_q          <= 1'b0;
          end else if (acc) begin
            if (ins) begin
              cnt_q <= cnt_q + CNT_W'(1);
              sum_q <= sum_q + SUM_W'(sample_value_i);
              if (sample_value_i < min_q) begin
                min_q <= sample_value_i;
              end
              if (sample_value_i > max_q) begin
                max_q <= sample_value_i;
              end
            end
            if (drop) begin
              ovf_q <= 1'b1;
            end
            if (list_end_i) begin
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (cnt_q == '0) begin
            valid_o        <= 1'b1;
            status_o       <= ST_NONE;
            valid_count_o  <= '0;
            mean_value_o   <= '0;
            median_value_o <= '0;
            min_value_o    <= '0;
            max_value_o    <= '0;
            sum_q          <= '0;
            min_q          <= {1'b0, {(DATA_W-1){1'b1}}};
            max_q          <= {1'b1, {(DATA_W-1){1'b0}}};
            ovf_q          <= 1'b0;
            state_q        <= S_IDLE;
          end else begin
            med_q   <= cnt_q >> 1;
            neg_q   <= sum_q[SUM_W-1];
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (med_q != '0) begin
            prev_q <= head;
            med_q  <= med_q - CNT_W'(1);
          end else if (!div_busy) begin
            valid_o        <= 1'b1;
            status_o       <= ovf_q ? ST_OVF : ST_OK;
            valid_count_o  <= cnt_q[VCNT_W-1:0];
            mean_value_o   <= mean_full[DATA_W-1:0];
            median_value_o <= median;
            min_value_o    <= min_q;
            max_value_o    <= max_q;
            cnt_q          <= '0;
            sum_q          <= '0;
            min_q          <= {1'b0, {(DATA_W-1){1'b1}}};
            max_q          <= {1'b1, {(DATA_W-1){1'b0}}};
            ovf_q          <= 1'b0;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stats_ordered = (min_value_o <= median_value_o) && (median_value_o <= max_value_o) &&
                         (min_value_o <= mean_value_o) && (mean_value_o <= max_value_o);

  `SSST_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_SAMPLES))
  `SSST_ASSERT_NEXT(a_empty_result, acc && empty_list_i, valid_o && status_o == ST_EMPTY)
  `SSST_ASSERT_NEXT(a_close_load, acc && list_end_i && !empty_list_i, state_q == S_LOAD)
  `SSST_ASSERT_IMPL(a_order, valid_o && (status_o == ST_OK || status_o == ST_OVF), stats_ordered)

endmodule

/* verif/sample_set_statistics_test.sv */
`timescale 1ns / 1ps

module sample_set_statistics_test;
  import ssst_pkg::*;

  localparam int ITEMS_TOTAL = 1900;
  localparam int CALM_TAIL   = 300;
  localparam int DRAIN_WAIT  = 150;
  localparam int PRINT_CAP   = 60;

  localparam logic signed [DATA_W-1:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MINV = 32'sh8000_0000;

  typedef struct packed {
    status_e                  status;
    logic [VCNT_W-1:0]        count;
    logic signed [DATA_W-1:0] mean;
    logic signed [DATA_W-1:0] median;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } stats_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     present;
    logic                     last;
    logic                     empty;
    logic                     typed;
    stats_t                   want;
  } sample_row_t;

  localparam stats_t NO_STATS    = '{ST_OK, 9'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam stats_t EMPTY_STATS = '{ST_EMPTY, 9'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam stats_t NONE_STATS  = '{ST_NONE, 9'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] sample_value_i;
  logic                     sample_present_i;
  logic                     list_end_i;
  logic                     empty_list_i;
  logic                     valid_o;
  logic [1:0]               status_o;
  logic [VCNT_W-1:0]        valid_count_o;
  logic signed [DATA_W-1:0] mean_value_o;
  logic signed [DATA_W-1:0] median_value_o;
  logic signed [DATA_W-1:0] min_value_o;
  logic signed [DATA_W-1:0] max_value_o;

  sample_set_statistics DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .sample_value_i   (sample_value_i),
    .sample_present_i (sample_present_i),
    .list_end_i       (list_end_i),
    .empty_list_i     (empty_list_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .valid_count_o    (valid_count_o),
    .mean_value_o     (mean_value_o),
    .median_value_o   (median_value_o),
    .min_value_o      (min_value_o),
    .max_value_o      (max_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_row_t opening_reqs [22] = '{
    '{32'sd0,       1'b0, 1'b0, 1'b1, 1'b1, EMPTY_STATS},
    '{32'sd0,       1'b0, 1'b1, 1'b0, 1'b1, NONE_STATS},
    '{32'sh1234,    1'b0, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{-32'sd1,      1'b0, 1'b1, 1'b0, 1'b1, NONE_STATS},
    '{MAXV,         1'b1, 1'b1, 1'b0, 1'b1, '{ST_OK, 9'd1, MAXV, MAXV, MAXV, MAXV}},
    '{MINV,         1'b1, 1'b1, 1'b0, 1'b1, '{ST_OK, 9'd1, MINV, MINV, MINV, MINV}},
    '{MINV,         1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{MAXV,         1'b1, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{32'sd5,       1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{32'sd7,       1'b1, 1'b1, 1'b1, 1'b1, EMPTY_STATS},
    '{32'sd0,       1'b1, 1'b1, 1'b0, 1'b1, '{ST_OK, 9'd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
    '{-32'sd3,      1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{32'sh100,     1'b0, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{-32'sd2,      1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{32'sd9,       1'b0, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{32'sd30,      1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{32'sd10,      1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{32'sd20,      1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{32'sd10,      1'b1, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{MAXV,         1'b1, 1'b0, 1'b0, 1'b0, NO_STATS},
    '{MAXV,         1'b1, 1'b1, 1'b0, 1'b0, NO_STATS},
    '{-32'sd1,      1'b1, 1'b1, 1'b1, 1'b1, EMPTY_STATS}
  };

  logic signed [DATA_W-1:0] kept_sorted [MAX_SAMPLES];
  int                       kept_n;
  longint                   kept_sum;
  logic signed [DATA_W-1:0] kept_lo;
  logic signed [DATA_W-1:0] kept_hi;
  bit                       kept_overflow;

  stats_t pending_stats [$];
  stats_t want_stats;
  int     mismatch_n;
  int     sent_n;
  bit     idle_on;

  function automatic void clear_stats();
    kept_n        = 0;
    kept_sum      = 0;
    kept_lo       = MAXV;
    kept_hi       = MINV;
    kept_overflow = 1'b0;
  endfunction

  function automatic void predict_stats(input sample_row_t r, output bit has,
                                        output stats_t res);
    logic signed [DATA_W-1:0] v;
    int                       pos;
    longint                   pair;
    v   = r.value;
    has = 1'b0;
    res = NO_STATS;
    if (r.empty) begin
      has        = 1'b1;
      res.status = ST_EMPTY;
      clear_stats();
    end else begin
      if (r.present) begin
        if (kept_n >= MAX_SAMPLES) begin
          kept_overflow = 1'b1;
        end else begin
          pos = kept_n;
          while (pos > 0 && kept_sorted[pos-1] > v) begin
            kept_sorted[pos] = kept_sorted[pos-1];
            pos--;
          end
          kept_sorted[pos] = v;
          kept_n++;
          kept_sum += v;
          if (v < kept_lo) kept_lo = v;
          if (v > kept_hi) kept_hi = v;
        end
      end
      if (r.last) begin
        has = 1'b1;
        if (kept_n == 0) begin
          res.status = ST_NONE;
        end else begin
          res.status = kept_overflow ? ST_OVF : ST_OK;
          res.count  = kept_n[VCNT_W-1:0];
          res.mean   = DATA_W'(kept_sum / longint'(kept_n));
          if (kept_n % 2 != 0) begin
            res.median = kept_sorted[kept_n/2];
          end else begin
            pair = longint'(kept_sorted[kept_n/2-1]) + longint'(kept_sorted[kept_n/2]);
            res.median = DATA_W'(pair >>> 1);
          end
          res.lo = kept_lo;
          res.hi = kept_hi;
        end
        clear_stats();
      end
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_sample();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0:       v = MAXV - $urandom_range(3);
      1:       v = MINV + $urandom_range(3);
      2, 3:    v = $urandom_range(2000) - 1000;
      4:       v = $urandom_range(4) * 256 - 512;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_n++;
    if (mismatch_n <= PRINT_CAP) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string what, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", what, got, want));
  endtask

  task automatic send_req(input sample_row_t r);
    bit     has;
    stats_t res;
    if (idle_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    end
    start            <= 1'b1;
    sample_value_i   <= r.value;
    sample_present_i <= r.present;
    list_end_i       <= r.last;
    empty_list_i     <= r.empty;
    do @(posedge clk_i); while (busy);
    predict_stats(r, has, res);
    if (has) pending_stats.push_back(r.typed ? r.want : res);
    sent_n++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_stats.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want_stats = pending_stats.pop_front();
        check_field("status", DATA_W'(status_o), DATA_W'(want_stats.status));
        check_field("valid_count", DATA_W'(valid_count_o), DATA_W'(want_stats.count));
        check_field("mean_value", mean_value_o, want_stats.mean);
        check_field("median_value", median_value_o, want_stats.median);
        check_field("min_value", min_value_o, want_stats.lo);
        check_field("max_value", max_value_o, want_stats.hi);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("sample_set_statistics verification failed");
    $finish;
  end

  initial begin
    sample_row_t r;
    int          list_len;
    int          lists_done;
    int          pick;
    int          abort_at;
    bit          all_present;
    bit          none_present;
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    sample_value_i   <= '0;
    sample_present_i <= 1'b0;
    list_end_i       <= 1'b0;
    empty_list_i     <= 1'b0;
    mismatch_n = 0;
    sent_n     = 0;
    lists_done = 0;
    clear_stats();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_reqs[i]) begin
      idle_on = 1'($urandom_range(1));
      send_req(opening_reqs[i]);
    end

    while (sent_n < ITEMS_TOTAL) begin
      idle_on      = (sent_n < ITEMS_TOTAL - CALM_TAIL) && ($urandom_range(2) != 0);
      pick         = $urandom_range(99);
      all_present  = 1'b0;
      none_present = (pick >= 8 && pick < 12);
      abort_at     = -1;
      if (lists_done == 0) begin
        list_len    = MAX_SAMPLES;
        all_present = 1'b1;
      end else if (lists_done == 1) begin
        list_len    = MAX_SAMPLES + 1 + $urandom_range(20);
        all_present = 1'b1;
      end else if (pick < 3) begin
        list_len = $urandom_range(MAX_SAMPLES + 30, 100);
      end else if (pick < 8) begin
        list_len = 0;
      end else begin
        list_len = $urandom_range(24, 1);
      end
      if (list_len > 1 && $urandom_range(19) == 0) abort_at = $urandom_range(list_len - 1);

      if (list_len == 0) begin
        r.value   = $urandom();
        r.present = 1'($urandom_range(1));
        r.last    = 1'($urandom_range(1));
        r.empty   = 1'b1;
        r.typed   = 1'b0;
        r.want    = NO_STATS;
        send_req(r);
      end else begin
        for (int i = 0; i < list_len; i++) begin
          r.value   = rand_sample();
          r.present = all_present || (!none_present && $urandom_range(7) != 0);
          r.last    = (i == list_len - 1);
          r.empty   = (i == abort_at);
          r.typed   = 1'b0;
          r.want    = NO_STATS;
          if (r.empty) begin
            r.present = 1'($urandom_range(1));
            r.last    = 1'($urandom_range(1));
          end
          send_req(r);
          if (r.empty) break;
        end
      end
      lists_done++;
      if (lists_done == 5 || $urandom_range(24) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_n == 0 && pending_stats.size() == 0) begin
      $display("sample_set_statistics verification clean");
    end else begin
      $display("sample_set_statistics verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ssst_pkg.sv
rtl/ssst_cell.sv
rtl/ssst_chain.sv
rtl/ssst_div.sv
rtl/sample_set_statistics.sv
verif/sample_set_statistics_test.sv
